### hdl/rhb_pkg.sv
// Shared types, constants and helpers for the range histogram binner.
`timescale 1ns / 1ps
`default_nettype none

package rhb_pkg;

    // Store geometry and count width
    localparam int NBINS      = 256;
    localparam int COUNT_BITS = 32;
    localparam int ADDR_W     = $clog2(NBINS);
    localparam int NB_W       = ADDR_W + 1;

    // Configuration register indexes
    localparam logic [2:0] CFG_RANGE_LOW     = 3'd0;
    localparam logic [2:0] CFG_RANGE_HIGH    = 3'd1;
    localparam logic [2:0] CFG_BIN_SCALE     = 3'd2;
    localparam logic [2:0] CFG_BINS_IN_USE   = 3'd3;
    localparam logic [2:0] CFG_BEYOND_MODE   = 3'd4;
    localparam logic [2:0] CFG_FILTER_ENABLE = 3'd5;
    localparam logic [2:0] CFG_GROUP_SELECT  = 3'd6;

    // Out-of-range handling codes
    localparam logic [1:0] MODE_IGNORE = 2'd0;
    localparam logic [1:0] MODE_FOLD   = 2'd1;
    localparam logic [1:0] MODE_EXTRA  = 2'd2;

    // Request codes
    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Access bundle for the bin store
    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [COUNT_BITS-1:0] wr_data;
        logic                  clear;
    } t_store_req;

    // Saturating increment of a count
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

### hdl/rhb_bin_store.sv
// Bin count memory with per-entry valid bits so that a clear drops every entry at once.
`timescale 1ns / 1ps
`default_nettype none

module rhb_bin_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rhb_pkg::t_store_req           i_req,
    output logic [rhb_pkg::COUNT_BITS-1:0]     o_rd_data
);
    import rhb_pkg::*;

    logic [COUNT_BITS-1:0] r_mem [NBINS];
    logic [NBINS-1:0]      r_valid;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_valid;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // Track written entries; clear drops all of them at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    // Unwritten entries read as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

### hdl/range_histogram_binner.sv
// Top level of the fixed-range histogram binner.
// Each accepted item passes through the multiply, address and write-back states before its result strobe.
// Items are handled one at a time, paced by the multiply stage and the
// read-modify-write on the single bin memory (accepted again in the strobe cycle).
// Reset: synchronous, active low; config, state, stats and all bins return to reset values
// at once through per-bin valid bits, so there is no clearing pass.
// The receiver cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module range_histogram_binner (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_sample_value,
    input  wire logic [31:0]        i_group_word,
    input  wire logic [7:0]         i_bin_index,
    output logic                    o_valid,
    output logic [31:0]             o_bin_count,
    output logic [31:0]             o_total_count,
    output logic [31:0]             o_outside_count,
    output logic signed [31:0]      o_min_value,
    output logic signed [31:0]      o_max_value
);
    import rhb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADDR,
        S_WB
    } t_state;

    // Configuration registers
    logic signed [31:0] r_range_low;
    logic signed [31:0] r_range_high;
    logic [31:0]        r_bin_scale;
    logic [NB_W-1:0]    r_bins_in_use;
    logic [1:0]         r_beyond_mode;
    logic               r_filter_en;
    logic [31:0]        r_group_sel;

    // Item and pipeline registers
    t_state             r_state;
    t_req               r_req;
    logic signed [31:0] r_sample;
    logic [31:0]        r_diff;
    logic               r_below;
    logic               r_above;
    logic               r_pass;
    logic [7:0]         r_bin_index;
    logic [31:0]        r_quot;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_inc;
    logic               r_out;

    // Stats and result registers
    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_outside;
    logic signed [31:0]    r_min;
    logic signed [31:0]    r_max;
    logic [COUNT_BITS-1:0] r_bin_count;
    logic                  r_valid;

    // Combinational helpers
    logic [63:0]           n_prod;
    logic                  n_mode_extra;
    logic                  n_mode_edges;
    logic [NB_W-1:0]       n_nb;
    logic [NB_W-1:0]       n_last;
    logic [NB_W-1:0]       n_idx;
    logic [ADDR_W-1:0]     n_addr;
    logic                  n_outside;
    logic                  n_inc;
    logic                  n_out;
    logic [COUNT_BITS-1:0] n_rd;
    t_store_req            n_store;

    assign busy = (r_state != S_IDLE);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low   <= 32'sd0;
            r_range_high  <= 32'sd65536;
            r_bin_scale   <= 32'd16777216;
            r_bins_in_use <= NB_W'(NBINS);
            r_beyond_mode <= MODE_IGNORE;
            r_filter_en   <= 1'b0;
            r_group_sel   <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_LOW:     r_range_low   <= i_cfg_wdata;
                CFG_RANGE_HIGH:    r_range_high  <= i_cfg_wdata;
                CFG_BIN_SCALE:     r_bin_scale   <= i_cfg_wdata;
                CFG_BINS_IN_USE:   r_bins_in_use <= i_cfg_wdata[NB_W-1:0];
                CFG_BEYOND_MODE:   r_beyond_mode <= i_cfg_wdata[1:0];
                CFG_FILTER_ENABLE: r_filter_en   <= i_cfg_wdata[0];
                CFG_GROUP_SELECT:  r_group_sel   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Scale the offset from the low bound into bin units
    assign n_prod = {32'd0, r_diff} * {32'd0, r_bin_scale};

    // Work out the effective bin count and the target bin
    always_comb begin
        n_mode_extra = (r_beyond_mode == MODE_EXTRA);
        n_mode_edges = (r_beyond_mode == MODE_FOLD) || n_mode_extra;

        if (r_bins_in_use == '0) begin
            n_nb = NB_W'(1);
        end else if (r_bins_in_use > NB_W'(NBINS)) begin
            n_nb = NB_W'(NBINS);
        end else begin
            n_nb = r_bins_in_use;
        end
        if (n_mode_extra && (n_nb < NB_W'(3))) begin
            n_nb = NB_W'(3);
        end

        n_last = n_mode_extra ? n_nb - NB_W'(3) : n_nb - NB_W'(1);
        n_idx  = (r_quot > 32'(n_last)) ? n_last : r_quot[NB_W-1:0];
        if (n_mode_extra) begin
            n_idx = n_idx + NB_W'(1);
        end

        priority if (r_req == REQ_READ) begin
            n_addr = ADDR_W'(r_bin_index);
        end else if (r_below) begin
            n_addr = '0;
        end else if (r_above) begin
            n_addr = n_last[ADDR_W-1:0] + (n_mode_extra ? ADDR_W'(2) : ADDR_W'(0));
        end else begin
            n_addr = n_idx[ADDR_W-1:0];
        end

        n_outside = r_below || r_above;
        n_inc     = (r_req == REQ_ADD) && r_pass && (!n_outside || n_mode_edges);
        n_out     = (r_req == REQ_ADD) && r_pass && n_outside && !n_mode_edges;
    end

    // Drive the bin store: read in the address stage, write back after
    always_comb begin
        n_store.rd_en   = (r_state == S_ADDR);
        n_store.rd_addr = n_addr;
        n_store.wr_en   = (r_state == S_WB) && r_inc;
        n_store.wr_addr = r_addr;
        n_store.wr_data = sat_inc(n_rd);
        n_store.clear   = (r_state == S_WB) && (r_req == REQ_CLEAR);
    end

    rhb_bin_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (n_store),
        .o_rd_data (n_rd)
    );

    // Sequence one item through multiply, address, write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_total   <= '0;
            r_outside <= '0;
            r_min     <= 32'sh7FFFFFFF;
            r_max     <= 32'sh80000000;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req       <= t_req'(i_req_type);
                        r_sample    <= i_sample_value;
                        r_diff      <= i_sample_value - r_range_low;
                        r_below     <= (i_sample_value < r_range_low);
                        r_above     <= (i_sample_value > r_range_high);
                        r_pass      <= !r_filter_en || ((i_group_word & r_group_sel) != '0);
                        r_bin_index <= i_bin_index;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_quot  <= n_prod[63:32];
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_addr  <= n_addr;
                    r_inc   <= n_inc;
                    r_out   <= n_out;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_bin_count <= (r_req == REQ_READ) ? n_rd : '0;
                    if (r_req == REQ_CLEAR) begin
                        r_total   <= '0;
                        r_outside <= '0;
                        r_min     <= 32'sh7FFFFFFF;
                        r_max     <= 32'sh80000000;
                    end else if ((r_req == REQ_ADD) && r_pass) begin
                        r_total <= sat_inc(r_total);
                        if (r_out) begin
                            r_outside <= sat_inc(r_outside);
                        end
                        if (r_sample < r_min) begin
                            r_min <= r_sample;
                        end
                        if (r_sample > r_max) begin
                            r_max <= r_sample;
                        end
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_bin_count     = r_bin_count;
    assign o_total_count   = r_total;
    assign o_outside_count = r_outside;
    assign o_min_value     = r_min;
    assign o_max_value     = r_max;

endmodule

`default_nettype wire
